@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/lsldd_pkg.sv @@
package lsldd_pkg;

    // board geometry
    localparam int HISTORY_DEPTH = 8;
    localparam int BOARD_SQUARES = 64;

    // fixed field widths
    localparam int SQ_IN_W    = 6;
    localparam int RAW_W      = 10;
    localparam int LVL_W      = 8;
    localparam int SLOPE_W    = 9;
    localparam int ICPT_W     = 12;
    localparam int CODE_W     = 2;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int LVL_MAX    = 255;

    // history memory addressing: {square, age}
    localparam int DW           = $clog2(HISTORY_DEPTH);
    localparam int SQ_W         = (BOARD_SQUARES > 1) ? $clog2(BOARD_SQUARES) : 1;
    localparam int HIST_AW      = SQ_W + DW;
    localparam int HIST_ENTRIES = BOARD_SQUARES * (1 << DW);

    // sequencer run phase covers the level divider and the history sweep
    localparam int RUN_LEN  = (HISTORY_DEPTH > LVL_W) ? HISTORY_DEPTH : LVL_W;
    localparam int CNT_W    = $clog2(RUN_LEN);
    localparam int DIV_W    = RAW_W + LVL_W;
    localparam int DIV_SH_W = $clog2(LVL_W);

    // least-squares constants, age as x
    localparam int XS  = HISTORY_DEPTH * (HISTORY_DEPTH - 1) / 2;
    localparam int X2S = (HISTORY_DEPTH - 1) * HISTORY_DEPTH * (2 * HISTORY_DEPTH - 1) / 6;
    localparam int DEN = HISTORY_DEPTH * X2S - XS * XS;

    // value bounds and widths of the fit datapath
    localparam int YS_MAX  = LVL_MAX * HISTORY_DEPTH;
    localparam int YS_W    = $clog2(YS_MAX + 1);
    localparam int XYS_MAX = LVL_MAX * XS;
    localparam int XYS_W   = $clog2(XYS_MAX + 1);
    localparam int NUM_MAX = HISTORY_DEPTH * XYS_MAX + XS * YS_MAX;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int SL_MAX  = NUM_MAX / DEN;
    localparam int SL_W    = $clog2(SL_MAX + 1);
    localparam int T_MAX   = YS_MAX + SL_MAX * XS;
    localparam int T_W     = $clog2(T_MAX + 1);
    localparam int IC_MAX  = T_MAX / HISTORY_DEPTH;
    localparam int IC_W    = $clog2(IC_MAX + 1);

    // reciprocal multipliers: floor(n / d) == (n * ceil(2^s / d)) >> s over the value range
    localparam int DEN_LOG = $clog2(DEN);
    localparam int S_SL    = NUM_W + DEN_LOG + 1;
    localparam int MSL_W   = S_SL - DEN_LOG + 2;
    localparam logic [MSL_W-1:0] M_SL =
        MSL_W'(((64'd1 << S_SL) + 64'(DEN) - 64'd1) / 64'(DEN));
    localparam int SLP_W   = NUM_W + MSL_W;

    localparam int S_IC    = T_W + DW + 1;
    localparam int MIC_W   = S_IC - DW + 2;
    localparam logic [MIC_W-1:0] M_IC =
        MIC_W'(((64'd1 << S_IC) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
    localparam int ICP_W   = T_W + MIC_W;

    // output saturation limits
    localparam logic signed [SLOPE_W-1:0] SLOPE_SAT_MAX = SLOPE_W'(255);
    localparam logic signed [SLOPE_W-1:0] SLOPE_SAT_MIN = SLOPE_W'(-256);
    localparam logic signed [ICPT_W-1:0]  ICPT_SAT_MAX  = ICPT_W'(2047);
    localparam logic signed [ICPT_W-1:0]  ICPT_SAT_MIN  = ICPT_W'(-2048);

    // register reset values
    localparam logic [RAW_W-1:0]          FULL_SCALE_RST = RAW_W'(250);
    localparam logic signed [ICPT_W-1:0]  LIFT_LEVEL_RST = ICPT_W'(200);
    localparam logic signed [SLOPE_W-1:0] LIFT_SLOPE_RST = SLOPE_W'(-20);
    localparam logic signed [ICPT_W-1:0]  DROP_LEVEL_RST = ICPT_W'(10);
    localparam logic signed [SLOPE_W-1:0] DROP_SLOPE_RST = SLOPE_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE = 3'd0,
        CFG_LIFT_LEVEL = 3'd1,
        CFG_LIFT_SLOPE = 3'd2,
        CFG_DROP_LEVEL = 3'd3,
        CFG_DROP_SLOPE = 3'd4
    } cfg_idx_t;

    typedef enum logic [CODE_W-1:0] {
        ST_INIT    = 2'd0,
        ST_LIFTED  = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE = 2'd0,
        EV_LIFT = 2'd1,
        EV_DROP = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_NUM,
        S_SLMUL,
        S_SLOPE,
        S_TERM,
        S_ICMUL,
        S_DONE
    } state_t;

endpackage

@@ rtl/light_sensor_lift_drop_detector_top.sv @@
// Lift/drop detector for a board of light-sensed squares. Each input item carries a square
// index and a raw 10-bit reading; the reading is clamped to full_scale, scaled to 0..255,
// inverted and pushed into that square's history, a least-squares line (age as x, newest at
// 0) is fitted over the history and its slope and intercept are tested against the lift and
// drop thresholds to update the square's status. Every item for a square on the board gives
// exactly one result item; an index past the board is taken and dropped without a result.
// For each item an 8-step shift-subtract divider for the level runs alongside the
// one-sample-per-cycle sweep of the history memory, then a six-step fit sequence with
// reciprocal multipliers for the two constant divides. Only one item is in flight; a finished
// result sits in the output register while the next item is taken. Histories and statuses
// live in two synchronous memories; a per-square valid bit makes unwritten rows read as zero
// history and init status, so no clearing pass is needed after reset. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module light_sensor_lift_drop_detector_top
    import lsldd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,

    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // square[5:0], raw_sample[15:6]

    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // square_out[5:0], level[13:6],
                                                  // slope[22:14], intercept[34:23],
                                                  // status[36:35], event_res[38:37], zero[39]
);

    // configuration registers
    logic [RAW_W-1:0]          full_scale_reg;
    logic signed [ICPT_W-1:0]  lift_level_reg;
    logic signed [SLOPE_W-1:0] lift_slope_reg;
    logic signed [ICPT_W-1:0]  drop_level_reg;
    logic signed [SLOPE_W-1:0] drop_slope_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // item and datapath registers
    logic [SQ_W-1:0]         sq_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [LVL_W-1:0]        quo_reg;
    logic [LVL_W-1:0]        lvl_reg;
    logic [YS_W-1:0]         ys_reg;
    logic [XYS_W-1:0]        xys_reg;
    logic                    num_neg_reg;
    logic [NUM_W-1:0]        num_mag_reg;
    logic [SLP_W-1:0]        slp_prod_reg;
    logic signed [SL_W:0]    slope_reg;
    logic                    t_neg_reg;
    logic [T_W-1:0]          t_mag_reg;
    logic [ICP_W-1:0]        icp_prod_reg;

    // memories and their read registers
    logic [LVL_W-1:0]         hist_mem [HIST_ENTRIES];
    logic [LVL_W-1:0]         hist_rd_reg;
    logic [CODE_W-1:0]        stat_mem [BOARD_SQUARES];
    logic [CODE_W-1:0]        stat_rd_reg;
    logic [BOARD_SQUARES-1:0] row_valid_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // control from the output decode
    logic                 hist_rd_en;
    logic [HIST_AW-1:0]   hist_rd_addr;
    logic                 hist_wr_en;
    logic [HIST_AW-1:0]   hist_wr_addr;
    logic [LVL_W-1:0]     hist_wr_data;
    logic                 out_load;

    // input fields
    logic [SQ_IN_W-1:0] in_square;
    logic [RAW_W-1:0]   in_raw;
    logic               in_accept;
    logic               in_range;

    assign in_square = s_axis_tdata[SQ_IN_W-1:0];
    assign in_raw    = s_axis_tdata[SQ_IN_W +: RAW_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_range  = 32'(in_square) < BOARD_SQUARES;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    //------------------------------------------------------------------
    // datapath combinational pieces
    //------------------------------------------------------------------

    // clamp and pre-scale the reading for the level divider
    logic [RAW_W-1:0] raw_clamped;
    logic [DIV_W-1:0] rem_init;
    assign raw_clamped = (in_raw > full_scale_reg) ? full_scale_reg : in_raw;
    assign rem_init    = DIV_W'(raw_clamped) * DIV_W'(LVL_MAX);

    // one quotient bit per cycle, most significant first
    logic [DIV_SH_W-1:0] div_sh;
    logic [DIV_W-1:0]    div_trial;
    logic                div_fit;
    logic                div_step;
    assign div_step  = int'(cnt_reg) < LVL_W;
    assign div_sh    = DIV_SH_W'(LVL_W - 1 - int'(cnt_reg));
    assign div_trial = DIV_W'(full_scale_reg) << div_sh;
    assign div_fit   = rem_reg >= div_trial;

    // inverted level; a zero full scale maps every reading to full level
    logic [LVL_W-1:0] level_c;
    assign level_c = (full_scale_reg == '0) ? LVL_W'(LVL_MAX) : LVL_W'(LVL_MAX) - quo_reg;

    // history sweep: old sample of age k lands at age k+1, read from age HISTORY_DEPTH-2 down
    logic [LVL_W-1:0] hist_old;
    logic             acc_step;
    logic [DW-1:0]    acc_age;
    assign hist_old = row_valid_reg[sq_reg] ? hist_rd_reg : '0;
    assign acc_step = (cnt_reg != '0) && (int'(cnt_reg) <= HISTORY_DEPTH - 1);
    assign acc_age  = DW'(HISTORY_DEPTH - int'(cnt_reg));

    // slope numerator
    logic [YS_W-1:0]  ys_total;
    logic [NUM_W:0]   num_a;
    logic [NUM_W:0]   num_b;
    logic [NUM_W:0]   num_c;
    assign ys_total = ys_reg + YS_W'(level_c);
    assign num_a    = (NUM_W+1)'(xys_reg) * (NUM_W+1)'(HISTORY_DEPTH);
    assign num_b    = (NUM_W+1)'(ys_total) * (NUM_W+1)'(XS);
    assign num_c    = num_a - num_b;

    // slope from the reciprocal product, truncated toward zero
    logic [SL_W-1:0] slope_q;
    assign slope_q = SL_W'(slp_prod_reg >> S_SL);

    // intercept numerator ys - slope * xs
    localparam logic signed [T_W:0] XS_T = (T_W+1)'(XS);
    logic signed [T_W:0] t_c;
    assign t_c = (T_W+1)'($signed({1'b0, ys_reg})) - (T_W+1)'(slope_reg) * XS_T;

    // intercept and the threshold tests on unsaturated values
    logic [IC_W-1:0]       icpt_q;
    logic signed [IC_W:0]  icpt_c;
    status_t               st_cur;
    status_t               st_mid;
    status_t               st_new;
    logic                  lift_hit;
    logic                  drop_hit;
    event_t                ev_c;
    logic signed [SLOPE_W-1:0] slope_sat;
    logic signed [ICPT_W-1:0]  icpt_sat;

    always_comb
    begin
        icpt_q = IC_W'(icp_prod_reg >> S_IC);
        icpt_c = t_neg_reg ? -$signed({1'b0, icpt_q}) : $signed({1'b0, icpt_q});
        st_cur = row_valid_reg[sq_reg] ? status_t'(stat_rd_reg) : ST_INIT;

        lift_hit = (icpt_c > lift_level_reg) && (slope_reg < lift_slope_reg)
                   && (st_cur != ST_LIFTED);
        st_mid   = lift_hit ? ST_LIFTED : st_cur;
        drop_hit = (icpt_c < drop_level_reg) && (slope_reg > drop_slope_reg)
                   && (st_mid != ST_DROPPED);
        st_new   = drop_hit ? ST_DROPPED : st_mid;

        if (drop_hit)
        begin
            ev_c = EV_DROP;
        end
        else if (lift_hit)
        begin
            ev_c = EV_LIFT;
        end
        else
        begin
            ev_c = EV_NONE;
        end

        if (slope_reg > SLOPE_SAT_MAX)
        begin
            slope_sat = SLOPE_SAT_MAX;
        end
        else if (slope_reg < SLOPE_SAT_MIN)
        begin
            slope_sat = SLOPE_SAT_MIN;
        end
        else
        begin
            slope_sat = SLOPE_W'(slope_reg);
        end

        if (icpt_c > ICPT_SAT_MAX)
        begin
            icpt_sat = ICPT_SAT_MAX;
        end
        else if (icpt_c < ICPT_SAT_MIN)
        begin
            icpt_sat = ICPT_SAT_MIN;
        end
        else
        begin
            icpt_sat = ICPT_W'(icpt_c);
        end
    end

    //------------------------------------------------------------------
    // sequencer: next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_accept && in_range)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (int'(cnt_reg) == RUN_LEN - 1)
                begin
                    state_next = S_NUM;
                    cnt_next   = '0;
                end
            end
            S_NUM:   state_next = S_SLMUL;
            S_SLMUL: state_next = S_SLOPE;
            S_SLOPE: state_next = S_TERM;
            S_TERM:  state_next = S_ICMUL;
            S_ICMUL: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // sequencer: memory and output controls
    //------------------------------------------------------------------
    always_comb
    begin
        hist_rd_en   = 1'b0;
        hist_rd_addr = {sq_reg, DW'(HISTORY_DEPTH - 2 - int'(cnt_reg))};
        hist_wr_en   = 1'b0;
        hist_wr_addr = {sq_reg, acc_age};
        hist_wr_data = hist_old;
        out_load     = 1'b0;
        case (state_reg)
            S_RUN:
            begin
                hist_rd_en = int'(cnt_reg) <= HISTORY_DEPTH - 2;
                hist_wr_en = acc_step;
            end
            S_NUM:
            begin
                // newest sample goes in at age zero
                hist_wr_en   = 1'b1;
                hist_wr_addr = {sq_reg, DW'(0)};
                hist_wr_data = level_c;
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                hist_rd_en = 1'b0;
            end
        endcase
    end

    //------------------------------------------------------------------
    // control registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg         <= 1'b1;
                row_valid_reg[sq_reg] <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FULL_SCALE_RST;
            lift_level_reg <= LIFT_LEVEL_RST;
            lift_slope_reg <= LIFT_SLOPE_RST;
            drop_level_reg <= DROP_LEVEL_RST;
            drop_slope_reg <= DROP_SLOPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FULL_SCALE: full_scale_reg <= cfg_wdata[RAW_W-1:0];
                CFG_LIFT_LEVEL: lift_level_reg <= cfg_wdata[ICPT_W-1:0];
                CFG_LIFT_SLOPE: lift_slope_reg <= cfg_wdata[SLOPE_W-1:0];
                CFG_DROP_LEVEL: drop_level_reg <= cfg_wdata[ICPT_W-1:0];
                CFG_DROP_SLOPE: drop_slope_reg <= cfg_wdata[SLOPE_W-1:0];
                default:        full_scale_reg <= full_scale_reg;
            endcase
        end
    end

    //------------------------------------------------------------------
    // datapath registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sq_reg  <= SQ_W'(in_square);
                rem_reg <= rem_init;
                quo_reg <= '0;
                ys_reg  <= '0;
                xys_reg <= '0;
            end
            S_RUN:
            begin
                if (div_step)
                begin
                    quo_reg <= {quo_reg[LVL_W-2:0], div_fit};
                    if (div_fit)
                    begin
                        rem_reg <= rem_reg - div_trial;
                    end
                end
                if (acc_step)
                begin
                    ys_reg  <= ys_reg + YS_W'(hist_old);
                    xys_reg <= xys_reg + XYS_W'(hist_old) * XYS_W'(acc_age);
                end
            end
            S_NUM:
            begin
                ys_reg      <= ys_total;
                lvl_reg     <= level_c;
                num_neg_reg <= num_c[NUM_W];
                num_mag_reg <= num_c[NUM_W] ? NUM_W'(-num_c) : NUM_W'(num_c);
            end
            S_SLMUL:
            begin
                slp_prod_reg <= SLP_W'(num_mag_reg) * SLP_W'(M_SL);
            end
            S_SLOPE:
            begin
                slope_reg <= num_neg_reg ? -$signed({1'b0, slope_q}) : $signed({1'b0, slope_q});
            end
            S_TERM:
            begin
                t_neg_reg <= t_c[T_W];
                t_mag_reg <= t_c[T_W] ? T_W'(-t_c) : T_W'(t_c);
            end
            S_ICMUL:
            begin
                icp_prod_reg <= ICP_W'(t_mag_reg) * ICP_W'(M_IC);
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase

        if (out_load)
        begin
            out_data_reg <= {1'b0, ev_c, st_new, icpt_sat, slope_sat, lvl_reg,
                             SQ_IN_W'(sq_reg)};
        end
    end

    // history memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (hist_wr_en)
        begin
            hist_mem[hist_wr_addr] <= hist_wr_data;
        end
        if (hist_rd_en)
        begin
            hist_rd_reg <= hist_mem[hist_rd_addr];
        end
    end

    // status memory: read follows the current square, written when the result is issued
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            stat_mem[sq_reg] <= st_new;
        end
        stat_rd_reg <= stat_mem[sq_reg];
    end

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    `ASSERT_PROP(a_load_from_done,
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE),
        "result appeared outside the done step")
    `ASSERT_PROP(a_div_settled,
        (state_reg == S_NUM && full_scale_reg != '0) |-> rem_reg < DIV_W'(full_scale_reg),
        "level divider remainder not below full scale")
    `ASSERT_NEVER(a_hist_wr_idle,
        hist_wr_en && state_reg == S_IDLE,
        "history written while idle")
    `ASSERT_PROP(a_lift_status,
        (out_valid_reg && out_data_reg[38:37] == EV_LIFT) |-> out_data_reg[36:35] == ST_LIFTED,
        "lift event without lifted status")

endmodule

@@ tb/testbench.sv @@
module testbench
    import lsldd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // run ends here if the scoreboard never drains
    localparam int CYCLE_LIMIT = 400000;
    // time from one acceptance to the next at the configured history depth, when the output does not stall
    localparam int ITEM_CYCLES = 7 + ((HISTORY_DEPTH > LVL_W) ? HISTORY_DEPTH : LVL_W);
    // at least this many random items per phase, four phases
    localparam int PHASE_ITEMS = 170;

    // one full register setting
    typedef struct {
        int fs;
        int ll;
        int ls;
        int dl;
        int ds;
    } thresholds_t;

    // one expected result item
    typedef struct {
        logic [SQ_IN_W-1:0]        sq;
        logic [LVL_W-1:0]          level;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
        status_t                   status;
        event_t                    ev;
    } fit_result_t;

    // shadow of the detector: per-square history and status, register copies,
    // and the fits still owed by the block
    class square_fit_board;
        int unsigned full_scale;
        int lift_level;
        int lift_slope;
        int drop_level;
        int drop_slope;
        bit [LVL_W-1:0] history [BOARD_SQUARES][HISTORY_DEPTH];
        status_t status_of [BOARD_SQUARES];
        fit_result_t expected_fits [$];
        int errors;

        function new();
            full_scale = 250;
            lift_level = 200;
            lift_slope = -20;
            drop_level = 10;
            drop_slope = 20;
            errors = 0;
            for (int s = 0; s < BOARD_SQUARES; s++)
            begin
                status_of[s] = ST_INIT;
                for (int d = 0; d < HISTORY_DEPTH; d++)
                    history[s][d] = '0;
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FULL_SCALE: full_scale = 32'(val[RAW_W-1:0]);
                CFG_LIFT_LEVEL: lift_level = int'($signed(val[ICPT_W-1:0]));
                CFG_LIFT_SLOPE: lift_slope = int'($signed(val[SLOPE_W-1:0]));
                CFG_DROP_LEVEL: drop_level = int'($signed(val[ICPT_W-1:0]));
                CFG_DROP_SLOPE: drop_slope = int'($signed(val[SLOPE_W-1:0]));
                default: ;
            endcase
        endfunction

        function int saturate(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // accepted reading: shift history, refit, update status
        function void note_reading(logic [SQ_IN_W-1:0] sq, logic [RAW_W-1:0] raw);
            int unsigned clipped;
            int unsigned scaled;
            int unsigned lvl;
            int xs;
            int ys;
            int x2s;
            int xys;
            int num;
            int den;
            int sl;
            int ic;
            fit_result_t r;
            event_t ev;
            if (sq >= BOARD_SQUARES)
                return;
            scaled = 0;
            if (full_scale != 0)
            begin
                clipped = (32'(raw) > full_scale) ? full_scale : 32'(raw);
                scaled = (clipped * 255) / full_scale;
            end
            lvl = 255 - scaled;
            for (int d = HISTORY_DEPTH - 1; d > 0; d--)
                history[sq][d] = history[sq][d-1];
            history[sq][0] = lvl[LVL_W-1:0];
            xs = 0;
            ys = 0;
            x2s = 0;
            xys = 0;
            for (int d = 0; d < HISTORY_DEPTH; d++)
            begin
                xs += d;
                ys += int'(history[sq][d]);
                x2s += d * d;
                xys += d * int'(history[sq][d]);
            end
            num = HISTORY_DEPTH * xys - xs * ys;
            den = HISTORY_DEPTH * x2s - xs * xs;
            sl = num / den;
            ic = (ys - sl * xs) / HISTORY_DEPTH;
            // thresholds see the unsaturated fit; lift first so drop wins a tie
            ev = EV_NONE;
            if (ic > lift_level && sl < lift_slope && status_of[sq] != ST_LIFTED)
            begin
                status_of[sq] = ST_LIFTED;
                ev = EV_LIFT;
            end
            if (ic < drop_level && sl > drop_slope && status_of[sq] != ST_DROPPED)
            begin
                status_of[sq] = ST_DROPPED;
                ev = EV_DROP;
            end
            r.sq = sq;
            r.level = lvl[LVL_W-1:0];
            r.slope = SLOPE_W'(saturate(sl, -256, 255));
            r.icpt = ICPT_W'(saturate(ic, -2048, 2047));
            r.status = status_of[sq];
            r.ev = ev;
            expected_fits.push_back(r);
        endfunction

        function void compare_field(string name, int want_v, int got_v);
            if (want_v != got_v)
            begin
                $error("%s: expected %0d, actual %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            fit_result_t want;
            if (expected_fits.size() == 0)
            begin
                $error("result item for square %0d with nothing expected", data[5:0]);
                errors++;
                return;
            end
            want = expected_fits.pop_front();
            compare_field("square_out", int'(want.sq), int'(data[5:0]));
            compare_field("level", int'(want.level), int'(data[13:6]));
            compare_field("slope", int'(want.slope), int'($signed(data[22:14])));
            compare_field("intercept", int'(want.icpt), int'($signed(data[34:23])));
            compare_field("status", int'(want.status), int'(data[36:35]));
            compare_field("event_res", int'(want.ev), int'(data[38:37]));
        endfunction

        function int pending();
            return expected_fits.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    square_fit_board board = new();

    // idle odds in percent, changed only between phases
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    // full scale in force, steers the burst readings
    int cur_fs = 250;
    int cycle_count = 0;

    light_sensor_lift_drop_detector_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // hard stop in case a result never shows up
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one item to the block; called at a rising edge, returns at the accepting edge
    task automatic push_reading(input logic [SQ_IN_W-1:0] sq, input logic [RAW_W-1:0] raw);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {raw, sq};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_reading(sq, raw);
    endtask

    // stop sending and wait for every owed result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        board.set_reg(idx, CFG_W'(value));
        @(posedge clk);
    endtask

    // all five registers, only while the block is idle
    task automatic apply_settings(input thresholds_t t);
        write_reg(CFG_FULL_SCALE, t.fs);
        write_reg(CFG_LIFT_LEVEL, t.ll);
        write_reg(CFG_LIFT_SLOPE, t.ls);
        write_reg(CFG_DROP_LEVEL, t.dl);
        write_reg(CFG_DROP_SLOPE, t.ds);
        cfg_we <= 1'b0;
        cur_fs = t.fs;
    endtask

    // covered square reads dark (low raw, high level), open square reads bright
    function automatic logic [RAW_W-1:0] pick_raw(input bit dark);
        if (dark)
            return RAW_W'($urandom_range(cur_fs / 8, 0));
        if ($urandom_range(3) == 0)
            return RAW_W'($urandom_range(1023, cur_fs));
        return RAW_W'($urandom_range(cur_fs, cur_fs - cur_fs / 8));
    endfunction

    // mostly runs of one square moving between dark and bright, some noise
    task automatic run_random(input int count);
        int made;
        int len;
        bit dark;
        logic [SQ_IN_W-1:0] sq;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 70)
            begin
                sq = SQ_IN_W'($urandom_range(BOARD_SQUARES - 1));
                len = $urandom_range(10, 3);
                dark = 1'($urandom_range(1));
                for (int k = 0; k < len; k++)
                    push_reading(sq, pick_raw(dark));
                made += len;
            end
            else
            begin
                push_reading(SQ_IN_W'($urandom), RAW_W'($urandom));
                made++;
            end
        end
    endtask

    initial
    begin
        thresholds_t phase_cfg [4];
        int gap_pct [4];
        int stall_pct [4];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset thresholds: extremes of both fields and the clamp edge
        push_reading(6'd0, 10'd0);
        push_reading(6'd63, 10'd1023);
        push_reading(6'd1, 10'd250);
        push_reading(6'd1, 10'd251);
        // square gets covered: lift after a few dark readings
        for (int k = 0; k < 5; k++)
            push_reading(6'd9, 10'd0);
        // then uncovered: drop as the bright readings pile up
        for (int k = 0; k < 5; k++)
            push_reading(6'd9, 10'd250);
        settle();

        // zero full scale: every reading maps to full level
        apply_settings('{fs: 0, ll: 200, ls: -20, dl: 10, ds: 20});
        push_reading(6'd2, 10'd0);
        push_reading(6'd2, 10'd1023);
        settle();

        // lift and drop both pass: drop wins every time
        apply_settings('{fs: 250, ll: -2048, ls: 255, dl: 2047, ds: -256});
        push_reading(6'd3, 10'd100);
        push_reading(6'd3, 10'd100);
        settle();

        // opposite extremes: nothing can ever fire
        apply_settings('{fs: 1023, ll: 2047, ls: -256, dl: -2048, ds: 255});
        push_reading(6'd4, 10'd1023);
        push_reading(6'd4, 10'd0);
        settle();

        // smallest full scale: any nonzero reading is full bright
        apply_settings('{fs: 1, ll: 200, ls: -20, dl: 10, ds: 20});
        push_reading(6'd5, 10'd0);
        push_reading(6'd5, 10'd1);
        push_reading(6'd5, 10'd1023);
        settle();

        // random phases, each with its own idling pattern and setting
        phase_cfg[0] = '{fs: 250, ll: 200, ls: -20, dl: 10, ds: 20};
        phase_cfg[1] = '{fs: 1023, ll: 120, ls: -8, dl: 60, ds: 8};
        phase_cfg[2] = '{fs: 1, ll: 150, ls: -30, dl: 30, ds: 30};
        phase_cfg[3] = '{fs: $urandom_range(1023, 1), ll: $urandom_range(230, 50),
                         ls: -$urandom_range(60, 1), dl: $urandom_range(80, 0),
                         ds: $urandom_range(60, 1)};
        gap_pct = '{0, 52, 0, 22};
        stall_pct = '{0, 0, 52, 22};
        for (int p = 0; p < 4; p++)
        begin
            apply_settings(phase_cfg[p]);
            send_gap_pct = gap_pct[p];
            recv_stall_pct = stall_pct[p];
            run_random(PHASE_ITEMS);
            settle();
        end

        // let any stray result surface
        repeat (3 * ITEM_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
